// File: src/mfps_pkg.sv
`timescale 1ns / 1ps
// Shared widths, defaults and stage types for the minimum falling path sum block.
// No dependencies; every other file of the block imports this package.
package mfps_pkg;

   // Fixed field widths
   localparam int CELL_W = 16;
   localparam int CFG_W  = 9;
   localparam int OUT_W  = 32;

   // Defaults for the top-level parameters
   localparam int DEF_MAX_COLUMNS = 256;
   localparam int DEF_SUM_WIDTH   = 32;

   // Reset value of the row width register
   localparam logic [CFG_W-1:0] CSR_COLUMN_COUNT_RESET = 9'd256;

   // One element as it sits in the compute stage
   typedef struct packed {
      logic signed [CELL_W-1:0] cell_value;
      logic                     last_element;
      logic                     first_row;
      logic                     first_col;
      logic                     row_end;
   } mfps_item_type;

   // Side information that travels with a best sum into the reduce stage
   typedef struct packed {
      logic last_element;
      logic first_col;
      logic saturated;
   } mfps_tag_type;

endpackage

// File: src/mfps_req_if.sv
`timescale 1ns / 1ps
// Element channel: valid/ready handshake carrying one matrix element.
// Depends on mfps_pkg for the field width.
interface mfps_req_if import mfps_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [CELL_W-1:0] cell_value;
   logic                     last_element;

   modport source (output valid, output cell_value, output last_element, input ready);
   modport sink   (input valid, input cell_value, input last_element, output ready);
endinterface

// File: src/mfps_rsp_if.sv
`timescale 1ns / 1ps
// Result channel: valid/ready handshake carrying the matrix minimum and flag.
// Depends on mfps_pkg for the field width.
interface mfps_rsp_if import mfps_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic signed [OUT_W-1:0] min_sum;
   logic                    saturated;

   modport source (output valid, output min_sum, output saturated, input ready);
   modport sink   (input valid, input min_sum, input saturated, output ready);
endinterface

// File: src/mfps_csr_if.sv
`timescale 1ns / 1ps
// Register write channel: valid/ready handshake carrying the row width.
// Depends on mfps_pkg for the field width.
interface mfps_csr_if import mfps_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [CFG_W-1:0] column_count;

   modport source (output valid, output column_count, input ready);
   modport sink   (input valid, input column_count, output ready);
endinterface

// File: src/mfps_line_buf.sv
`timescale 1ns / 1ps
// Line buffer of previous-row best sums: one write port, two registered read ports,
// with bypass of a same-cycle write. Depends on mfps_pkg only through the import.
module mfps_line_buf
   import mfps_pkg::*;
#(
   parameter int DEPTH  = DEF_MAX_COLUMNS,
   parameter int WIDTH  = DEF_SUM_WIDTH,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                    clock,
   input  logic                    wr_en,
   input  logic [ADDR_W-1:0]       wr_addr,
   input  logic signed [WIDTH-1:0] wr_data,
   input  logic                    rd_en,
   input  logic [ADDR_W-1:0]       rd_addr0,
   input  logic [ADDR_W-1:0]       rd_addr1,
   output logic signed [WIDTH-1:0] rd_data0,
   output logic signed [WIDTH-1:0] rd_data1
);

   logic signed [WIDTH-1:0] mem [DEPTH];
   logic signed [WIDTH-1:0] rd0_ff;
   logic signed [WIDTH-1:0] rd1_ff;
   logic signed [WIDTH-1:0] byp_data_ff;
   logic                    byp0_ff;
   logic                    byp1_ff;

   // Write, read both ports, and note a write to an address being read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd0_ff      <= mem[rd_addr0];
         rd1_ff      <= mem[rd_addr1];
         byp0_ff     <= wr_en && (wr_addr == rd_addr0);
         byp1_ff     <= wr_en && (wr_addr == rd_addr1);
         byp_data_ff <= wr_data;
      end
   end

   // Return the new data where the read raced the write
   assign rd_data0 = byp0_ff ? byp_data_ff : rd0_ff;
   assign rd_data1 = byp1_ff ? byp_data_ff : rd1_ff;

endmodule

// File: src/mfps_cell.sv
`timescale 1ns / 1ps
// Best-sum datapath for one element: three-way minimum of the sums above plus the element
// value, saturating; the first row takes the value alone. Depends on mfps_pkg types.
module mfps_cell
   import mfps_pkg::*;
#(
   parameter int SUM_WIDTH = DEF_SUM_WIDTH
) (
   input  mfps_item_type               item,
   input  logic signed [SUM_WIDTH-1:0] centre_above,
   input  logic signed [SUM_WIDTH-1:0] right_above,
   input  logic signed [SUM_WIDTH-1:0] left_above,
   output logic signed [SUM_WIDTH-1:0] best,
   output mfps_tag_type                tag
);

   localparam logic signed [SUM_WIDTH-1:0] SUM_MAX = {1'b0, {(SUM_WIDTH-1){1'b1}}};
   localparam logic signed [SUM_WIDTH-1:0] SUM_MIN = {1'b1, {(SUM_WIDTH-1){1'b0}}};

   logic signed [SUM_WIDTH-1:0] min_above;
   logic signed [SUM_WIDTH:0]   sum_wide;
   logic                        ovf;

   // Pick the least neighbor above; edge columns skip the missing side
   always_comb begin
      min_above = centre_above;
      if (!item.first_col && (left_above < min_above)) begin
         min_above = left_above;
      end
      if (!item.row_end && (right_above < min_above)) begin
         min_above = right_above;
      end
   end

   // Add with one guard bit, clamp on overflow
   always_comb begin
      sum_wide = (SUM_WIDTH+1)'(min_above) + (SUM_WIDTH+1)'(item.cell_value);
      ovf      = sum_wide[SUM_WIDTH] != sum_wide[SUM_WIDTH-1];
      if (item.first_row) begin
         best = SUM_WIDTH'(item.cell_value);
      end else if (ovf && !sum_wide[SUM_WIDTH]) begin
         best = SUM_MAX;
      end else if (ovf) begin
         best = SUM_MIN;
      end else begin
         best = sum_wide[SUM_WIDTH-1:0];
      end
   end

   assign tag.last_element = item.last_element;
   assign tag.first_col    = item.first_col;
   assign tag.saturated    = ovf && !item.first_row;

endmodule

// File: src/mfps_reduce.sv
`timescale 1ns / 1ps
// Row minimum tracking and result register: keeps the least best sum of the
// current row and emits it, clamped to 32 bits, on the last element. Uses mfps_pkg.
module mfps_reduce
   import mfps_pkg::*;
#(
   parameter int SUM_WIDTH = DEF_SUM_WIDTH
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  logic signed [SUM_WIDTH-1:0] in_best,
   input  mfps_tag_type                in_tag,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic signed [OUT_W-1:0]     rsp_min_sum,
   output logic                        rsp_saturated
);

   localparam int EXT_W = (SUM_WIDTH > OUT_W) ? SUM_WIDTH : OUT_W;
   localparam logic signed [SUM_WIDTH-1:0] SUM_MAX = {1'b0, {(SUM_WIDTH-1){1'b1}}};
   localparam logic signed [OUT_W-1:0]     OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
   localparam logic signed [OUT_W-1:0]     OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

   logic                        c_valid_ff, c_valid_in;
   logic signed [SUM_WIDTH-1:0] c_best_ff;
   mfps_tag_type                c_tag_ff;
   logic signed [SUM_WIDTH-1:0] row_min_ff, row_min_in;
   logic                        ovf_ff, ovf_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic signed [OUT_W-1:0]     rsp_min_sum_ff;
   logic                        rsp_saturated_ff;

   logic                        rsp_free;
   logic                        c_go;
   logic signed [SUM_WIDTH-1:0] row_min_new;
   logic signed [EXT_W-1:0]     min_ext;
   logic signed [OUT_W-1:0]     min_clamped;
   logic                        clamp_hit;

   // Stage handshake: only a last element waits for the result register
   assign rsp_free   = !rsp_valid_ff || rsp_ready;
   assign c_go       = c_valid_ff && (!c_tag_ff.last_element || rsp_free);
   assign in_ready   = !c_valid_ff || c_go;
   assign c_valid_in = (in_valid && in_ready) || (c_valid_ff && !c_go);

   // Fold this element into the row minimum; first column restarts it
   assign row_min_new = (c_tag_ff.first_col || (c_best_ff < row_min_ff)) ? c_best_ff
                                                                         : row_min_ff;

   // Clamp the matrix minimum to the result width
   always_comb begin
      min_ext = EXT_W'(row_min_new);
      if (min_ext > EXT_W'(OUT_MAX)) begin
         min_clamped = OUT_MAX;
         clamp_hit   = 1'b1;
      end else if (min_ext < EXT_W'(OUT_MIN)) begin
         min_clamped = OUT_MIN;
         clamp_hit   = 1'b1;
      end else begin
         min_clamped = OUT_W'(min_ext);
         clamp_hit   = 1'b0;
      end
   end

   // Next running state: restart after the last element
   always_comb begin
      row_min_in   = row_min_ff;
      ovf_in       = ovf_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (c_go) begin
         if (c_tag_ff.last_element) begin
            row_min_in   = SUM_MAX;
            ovf_in       = 1'b0;
            rsp_valid_in = 1'b1;
         end else begin
            row_min_in = row_min_new;
            ovf_in     = ovf_ff || c_tag_ff.saturated;
         end
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff   <= 1'b0;
         row_min_ff   <= SUM_MAX;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         c_valid_ff   <= c_valid_in;
         row_min_ff   <= row_min_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         c_best_ff <= in_best;
         c_tag_ff  <= in_tag;
      end
      if (c_go && c_tag_ff.last_element) begin
         rsp_min_sum_ff   <= min_clamped;
         rsp_saturated_ff <= ovf_ff || c_tag_ff.saturated || clamp_hit;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_min_sum   = rsp_min_sum_ff;
   assign rsp_saturated = rsp_saturated_ff;

endmodule

// File: src/min_falling_path_sum.sv
`timescale 1ns / 1ps
// Top level of the minimum falling path sum block: column tracking, line buffer,
// best-sum stage and result stage. Depends on mfps_pkg, the three channel interfaces,
// mfps_line_buf, mfps_cell and mfps_reduce.
//
//   Channel  Dir  Payload                          Transaction when
//   req_if   in   cell_value[15:0], last_element   valid && ready
//   rsp_if   out  min_sum[31:0], saturated         valid && ready
//   csr_if   in   column_count[8:0]                valid && ready (ready is always high)
//
// One element is taken per clock while no stalled result holds the pipeline; the
// line buffer's two read ports fetch the sums above the next element while the
// previous element writes its own sum back. Results leave from the result register.
// Reset clears the control state and sets the row width to 256; the line buffer
// is not cleared, since every entry is written in the first row before it is used.
// A stalled result holds only the result stage; elements keep flowing until a
// second last element reaches the stage in front of it.
module min_falling_path_sum
   import mfps_pkg::*;
#(
   parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
   parameter int SUM_WIDTH   = DEF_SUM_WIDTH
) (
   input  logic         clock,
   input  logic         reset,
   mfps_req_if.sink     req_if,
   mfps_rsp_if.source   rsp_if,
   mfps_csr_if.sink     csr_if
);

   localparam int IDX_W = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
   localparam int CNT_W = $clog2(MAX_COLUMNS + 1);

   logic [CFG_W-1:0]            csr_column_count_ff;
   logic [IDX_W-1:0]            col_idx_ff, col_idx_in;
   logic                        first_row_ff, first_row_in;
   logic                        s1_valid_ff, s1_valid_in;
   mfps_item_type               s1_item_ff;
   logic [IDX_W-1:0]            s1_idx_ff;
   logic signed [SUM_WIDTH-1:0] left_ff;

   logic [CNT_W-1:0]            cols_eff;
   logic                        row_end;
   logic                        accept;
   logic                        s1_go;
   logic                        c_ready;
   logic signed [SUM_WIDTH-1:0] centre_above;
   logic signed [SUM_WIDTH-1:0] right_above;
   logic signed [SUM_WIDTH-1:0] best;
   mfps_tag_type                tag;

   // Effective row width: zero acts as one, oversize acts as the buffer depth
   always_comb begin
      if (csr_column_count_ff == '0) begin
         cols_eff = CNT_W'(1);
      end else if (32'(csr_column_count_ff) > 32'(MAX_COLUMNS)) begin
         cols_eff = CNT_W'(MAX_COLUMNS);
      end else begin
         cols_eff = CNT_W'(csr_column_count_ff);
      end
   end

   assign row_end = (CNT_W'(col_idx_ff) + CNT_W'(1)) >= cols_eff;

   // Pipeline handshake
   assign s1_go         = s1_valid_ff && c_ready;
   assign req_if.ready  = !s1_valid_ff || s1_go;
   assign accept        = req_if.valid && req_if.ready;
   assign s1_valid_in   = accept || (s1_valid_ff && !s1_go);
   assign csr_if.ready  = 1'b1;

   // Advance the column position on each element
   always_comb begin
      col_idx_in   = col_idx_ff;
      first_row_in = first_row_ff;
      if (accept) begin
         if (req_if.last_element) begin
            col_idx_in   = '0;
            first_row_in = 1'b1;
         end else if (row_end) begin
            col_idx_in   = '0;
            first_row_in = 1'b0;
         end else begin
            col_idx_in = col_idx_ff + IDX_W'(1);
         end
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         csr_column_count_ff <= CSR_COLUMN_COUNT_RESET;
         col_idx_ff          <= '0;
         first_row_ff        <= 1'b1;
         s1_valid_ff         <= 1'b0;
         left_ff             <= '0;
      end else begin
         if (csr_if.valid && csr_if.ready) begin
            csr_column_count_ff <= csr_if.column_count;
         end
         col_idx_ff   <= col_idx_in;
         first_row_ff <= first_row_in;
         s1_valid_ff  <= s1_valid_in;
         if (s1_go && !s1_item_ff.first_row) begin
            left_ff <= centre_above;
         end
      end
   end

   // Capture the element as its line buffer reads go out
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_item_ff.cell_value   <= req_if.cell_value;
         s1_item_ff.last_element <= req_if.last_element;
         s1_item_ff.first_row    <= first_row_ff;
         s1_item_ff.first_col    <= (col_idx_ff == '0);
         s1_item_ff.row_end      <= row_end;
         s1_idx_ff               <= col_idx_ff;
      end
   end

   mfps_line_buf #(
      .DEPTH  (MAX_COLUMNS),
      .WIDTH  (SUM_WIDTH),
      .ADDR_W (IDX_W)
   ) u_line_buf (
      .clock    (clock),
      .wr_en    (s1_go),
      .wr_addr  (s1_idx_ff),
      .wr_data  (best),
      .rd_en    (accept),
      .rd_addr0 (col_idx_ff),
      .rd_addr1 (col_idx_ff + IDX_W'(1)),
      .rd_data0 (centre_above),
      .rd_data1 (right_above)
   );

   mfps_cell #(
      .SUM_WIDTH (SUM_WIDTH)
   ) u_cell (
      .item         (s1_item_ff),
      .centre_above (centre_above),
      .right_above  (right_above),
      .left_above   (left_ff),
      .best         (best),
      .tag          (tag)
   );

   mfps_reduce #(
      .SUM_WIDTH (SUM_WIDTH)
   ) u_reduce (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (s1_valid_ff),
      .in_ready      (c_ready),
      .in_best       (best),
      .in_tag        (tag),
      .rsp_valid     (rsp_if.valid),
      .rsp_ready     (rsp_if.ready),
      .rsp_min_sum   (rsp_if.min_sum),
      .rsp_saturated (rsp_if.saturated)
   );

endmodule

// File: src/mfps_checker.sv
`timescale 1ns / 1ps
// Port-level checks for min_falling_path_sum, attached by the bind below.
// Depends on mfps_pkg and on the top level's ports only.
module mfps_checker
   import mfps_pkg::*;
(
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_ready,
   input logic                    req_last_element,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input logic signed [OUT_W-1:0] rsp_min_sum,
   input logic                    rsp_saturated
);

   logic [2:0] pending_ff, pending_in;

   // Count last elements taken whose result has not yet gone out
   always_comb begin
      pending_in = pending_ff;
      if (req_valid && req_ready && req_last_element) begin
         pending_in = pending_in + 3'd1;
      end
      if (rsp_valid && rsp_ready) begin
         pending_in = pending_in - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   // A stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   // A stalled result keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_min_sum) && $stable(rsp_saturated))
      else $error("result payload changed while stalled");

   // Every result belongs to a last element already taken
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != 3'd0)
      else $error("result without a pending last element");

   // No more matrices in flight than the pipeline holds
   a_depth: assert property (@(posedge clock) disable iff (reset)
      pending_ff <= 3'd3)
      else $error("too many matrices in flight");

   // Nothing is offered right after reset
   a_reset_idle: assert property (@(posedge clock)
      $fell(reset) |-> !rsp_valid)
      else $error("result offered out of reset");

endmodule

bind min_falling_path_sum mfps_checker u_mfps_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_if.valid),
   .req_ready        (req_if.ready),
   .req_last_element (req_if.last_element),
   .rsp_valid        (rsp_if.valid),
   .rsp_ready        (rsp_if.ready),
   .rsp_min_sum      (rsp_if.min_sum),
   .rsp_saturated    (rsp_if.saturated)
);
